// File: src/md5_digest_engine_unit_assert.svh
// Assertion macros for the MD5 digest engine.
`ifndef MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH
`define MD5_DIGEST_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MD5_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg)
`define MD5_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: src/md5_pkg.sv
// Package: MD5 constants, types and round helper functions.
`default_nettype none
package md5_pkg;
  localparam int unsigned QueueDepth = 2;
  typedef enum logic {REQ_ABSORB = 1'b0, REQ_FINISH = 1'b1} req_e;
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } rsp_t;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;  6'd2: k = 32'h242070DB;
      6'd3: k = 32'hC1BDCEEE;  6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;  6'd8: k = 32'h698098D8;
      6'd9: k = 32'h8B44F7AF;  6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] msg_sel(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

// File: src/md5_stream_if.sv
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface md5_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/md5_digest_engine_unit.sv
// Top level of the MD5 digest engine.
//
//  channel | dir | payload
//  req_i   | in  | req_type (1b), data_byte (8b)
//  rsp_o   | out | digest_word (32b), word_index (2b), last_word (1b)
//
// An absorb request writes one byte into the block buffer; the 64th byte of a
// block also starts the 64 rounds of a compression (one MD5 round per cycle).
// A finish request zero-fills to byte 56, writes the length,
// runs one or two compressions, then offers four words.
// Reset (async, active low) loads the initial chaining words and empties the queue.
// The two-entry queue accepts up to two requests while the core compresses.
`default_nettype none
`include "md5_digest_engine_unit_assert.svh"
module md5_digest_engine_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  md5_stream_if.sink   req_i,
  md5_stream_if.source rsp_o
);
  logic          full, empty, pop;
  md5_pkg::req_t head;

  // accept whenever the queue has room
  assign req_i.ready = !full;

  md5_req_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(req_i.valid), .push_data_i(req_i.payload), .full_o(full),
    .pop_i(pop), .pop_data_o(head), .empty_o(empty)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .req_valid_i(!empty), .req_i(head), .req_pop_o(pop), .rsp_o(rsp_o)
  );

  `MD5_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop |-> !empty, "pop from empty queue")
  `MD5_ASSERT(a_ready_room, clk_i, rst_ni, req_i.ready == !full, "ready mismatch")
  `MD5_ASSERT_RST(a_rst_quiet, clk_i, !rst_ni |=> !rsp_o.valid, "valid after reset")
endmodule
`default_nettype wire

// File: src/md5_req_fifo.sv
// Short request queue between the intake and the compression core.
`default_nettype none
module md5_req_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire md5_pkg::req_t push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output md5_pkg::req_t     pop_data_o,
  output logic              empty_o
);
  md5_pkg::req_t mem_q [md5_pkg::QueueDepth];
  logic [0:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(md5_pkg::QueueDepth));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule
`default_nettype wire

// File: src/md5_core.sv
// Back end: block buffer, padding sequencer, one round per cycle, digest output.
`default_nettype none
`include "md5_digest_engine_unit_assert.svh"
module md5_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  input  wire md5_pkg::req_t req_i,
  output logic           req_pop_o,
  md5_stream_if.source   rsp_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_ROUND, S_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] buf_q [16];  // block held as 16 little-endian message words
  logic [5:0]  fill_q;
  logic [60:0] count_q;
  logic [31:0] cv_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  rnd_q;
  logic        final_q;   // compression belongs to the finish sequence
  logic        more_q;    // another padded block follows this compression
  logic [1:0]  widx_q;
  logic        rsp_valid_q;

  logic [3:0]  g;
  logic [31:0] m_word, f, sum, rot, new_b;
  logic [63:0] bits;

  assign g = md5_pkg::msg_sel(rnd_q);
  assign m_word = buf_q[g];
  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end
  assign sum   = a_q + f + md5_pkg::sine_k(rnd_q) + m_word;
  assign rot   = (sum << md5_pkg::rot_amt(rnd_q)) | (sum >> (6'd32 - 6'(md5_pkg::rot_amt(rnd_q))));
  assign new_b = b_q + rot;
  assign bits  = {count_q, 3'b000};

  assign req_pop_o     = (state_q == S_IDLE) && req_valid_i;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = '{digest_word: cv_q[widx_q], word_index: widx_q,
                           last_word: (widx_q == 2'd3)};

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <=
          (req_i.req_type == md5_pkg::REQ_FINISH) ? md5_pkg::PadMark : req_i.data_byte;
      end
      S_PAD: buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= 8'h00;
      S_LEN: begin
        // length field fills the last two words
        buf_q[4'd14] <= bits[31:0];
        buf_q[4'd15] <= bits[63:32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0; count_q <= '0;
      cv_q[0] <= md5_pkg::InitA; cv_q[1] <= md5_pkg::InitB;
      cv_q[2] <= md5_pkg::InitC; cv_q[3] <= md5_pkg::InitD;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      rnd_q <= '0; final_q <= 1'b0; more_q <= 1'b0;
      widx_q <= '0; rsp_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            fill_q <= fill_q + 6'd1;
            a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
            rnd_q <= '0;
            if (req_i.req_type == md5_pkg::REQ_ABSORB) begin
              count_q <= count_q + 61'd1;
              final_q <= 1'b0;
              if (fill_q == 6'd63) state_q <= S_ROUND;
            end else begin
              final_q <= 1'b1;
              more_q  <= (fill_q >= md5_pkg::LenPos);
              if (fill_q == 6'd63) state_q <= S_ROUND;
              // marker lands right before the length field: nothing to zero
              else if (fill_q == md5_pkg::LenPos - 6'd1) state_q <= S_LEN;
              else state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // zero up to the length field, or to the block end when it spills over
          fill_q <= fill_q + 6'd1;
          if (!more_q && fill_q == md5_pkg::LenPos - 6'd1) state_q <= S_LEN;
          else if (more_q && fill_q == 6'd63) state_q <= S_ROUND;
        end
        S_LEN: begin
          // reload the working words: a spill-over block may have updated the chain
          a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
          rnd_q <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          a_q <= d_q; b_q <= new_b; c_q <= b_q; d_q <= c_q;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            cv_q[0] <= cv_q[0] + d_q; cv_q[1] <= cv_q[1] + new_b;
            cv_q[2] <= cv_q[2] + b_q; cv_q[3] <= cv_q[3] + c_q;
            fill_q <= '0;
            if (!final_q) state_q <= S_IDLE;
            else if (more_q) begin
              more_q <= 1'b0;
              state_q <= S_PAD;
            end else begin
              state_q <= S_EMIT;
              rsp_valid_q <= 1'b1;
              widx_q <= '0;
            end
          end
        end
        S_EMIT: begin
          if (rsp_o.ready) begin
            widx_q <= widx_q + 2'd1;
            if (widx_q == 2'd3) begin
              rsp_valid_q <= 1'b0;
              state_q <= S_IDLE;
              fill_q <= '0; count_q <= '0; final_q <= 1'b0;
              cv_q[0] <= md5_pkg::InitA; cv_q[1] <= md5_pkg::InitB;
              cv_q[2] <= md5_pkg::InitC; cv_q[3] <= md5_pkg::InitD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MD5_ASSERT(a_valid_emit, clk_i, rst_ni, rsp_valid_q == (state_q == S_EMIT), "valid outside emit")
  `MD5_ASSERT(a_no_pop_busy, clk_i, rst_ni, req_pop_o |-> state_q == S_IDLE, "pop while busy")
  `MD5_ASSERT(a_round_wrap, clk_i, rst_ni, (state_q == S_ROUND && rnd_q == 6'd63) |=> state_q != S_ROUND, "round overrun")
endmodule
`default_nettype wire
